@@ src/sal_pkg.sv @@
// shared types and constants for the shelf atlas allocator
package sal_pkg;

  localparam int unsigned CURSOR_W   = 14;
  localparam int unsigned CFG_W      = 14;
  localparam int unsigned SIDE_MIN   = 16;
  localparam int unsigned SIDE_RESET = 1024;

  // floor(x / 3) == (x * DIV3_RECIP) >> DIV3_SHIFT for every 12-bit x
  localparam logic [12:0] DIV3_RECIP = 13'd5462;
  localparam int unsigned DIV3_SHIFT = 14;

  typedef enum logic {
    OP_PLACE = 1'b0,
    OP_CLEAR = 1'b1
  } sal_op_t;

  typedef enum logic [1:0] {
    KIND_MASK   = 2'd0,
    KIND_COLOR  = 2'd1,
    KIND_LCD    = 2'd2,
    KIND_UNUSED = 2'd3
  } sal_kind_t;

  typedef struct packed {
    logic        operation;
    logic [11:0] bitmap_width;
    logic [9:0]  bitmap_height;
    logic [1:0]  glyph_kind;
  } sal_in_t;

  typedef struct packed {
    logic [12:0] pos_u;
    logic [12:0] pos_v;
    logic [11:0] placed_width;
    logic [9:0]  placed_height;
    logic        grew;
    logic        no_room;
  } sal_out_t;

endpackage

@@ src/shelf_atlas_allocator.sv @@
// shelf packing allocator for a square glyph atlas
// each accepted beat's placement is registered, into the skid stage if the output is held
// throughput: one beat per cycle unless stalled; placement is one pass of adds and compares
// the output register has a skid stage behind it, so input is stalled only when both are full
// reset (synchronous, active low): cursor and shelf cleared, atlas side = min(1024, MAX_SIDE)
// a configuration write loads the limited side and clears the shelf as reset does
module shelf_atlas_allocator #(
  parameter int unsigned MAX_SIDE = 8192
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sal_pkg::sal_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sal_pkg::sal_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [sal_pkg::CFG_W-1:0]         cfg_wdata
);
  import sal_pkg::*;

  localparam int unsigned SIDE_W     = $clog2(MAX_SIDE) + 1;
  localparam int unsigned CALC_W     = (SIDE_W > 15) ? SIDE_W + 1 : 16;
  localparam int unsigned RESET_SIDE = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;

  logic [CURSOR_W-1:0] cursor_x_r, cursor_x_nxt;
  logic [CURSOR_W-1:0] shelf_top_r, shelf_top_nxt;
  logic [9:0]          shelf_tall_r, shelf_tall_nxt;
  logic [SIDE_W-1:0]   atlas_side_r, atlas_side_nxt;

  logic                out_valid_r, skid_valid_r;
  sal_out_t            out_data_r, skid_data_r;

  logic                in_accept, out_take;
  logic                is_lcd, empty_rect, wrap, vfail, at_max;
  logic [24:0]         div_prod;
  logic [11:0]         aw;
  logic [CALC_W-1:0]   side_ext, row_end, ny, ny_fin, cfg_ext, side_dbl;
  logic [CURSOR_W-1:0] nx, nx_fin;
  logic [9:0]          nt, nt_fin;
  logic [SIDE_W-1:0]   side_grown, cfg_side;
  sal_out_t            result;

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // placement datapath
  assign is_lcd     = (in_data.glyph_kind == KIND_LCD);
  assign div_prod   = 25'(in_data.bitmap_width) * 25'(DIV3_RECIP);
  assign aw         = is_lcd ? 12'(div_prod[24:DIV3_SHIFT]) : in_data.bitmap_width;
  assign empty_rect = (in_data.bitmap_width == '0) || (in_data.bitmap_height == '0);

  assign side_ext = CALC_W'(atlas_side_r);
  assign row_end  = CALC_W'(cursor_x_r) + CALC_W'(aw) + CALC_W'(1);
  assign wrap     = row_end > side_ext;
  assign nx       = wrap ? '0 : cursor_x_r;
  assign ny       = wrap ? CALC_W'(shelf_top_r) + CALC_W'(shelf_tall_r) + CALC_W'(1)
                         : CALC_W'(shelf_top_r);
  assign nt       = wrap ? '0 : shelf_tall_r;
  assign vfail    = (ny + CALC_W'(in_data.bitmap_height)) > side_ext;
  assign at_max   = CALC_W'(atlas_side_r) >= CALC_W'(MAX_SIDE);

  assign side_dbl   = CALC_W'(atlas_side_r) << 1;
  assign side_grown = (side_dbl > CALC_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(side_dbl);

  assign nx_fin = vfail ? '0 : nx;
  assign ny_fin = vfail ? '0 : ny;
  assign nt_fin = vfail ? '0 : nt;

  // register write value limited to the legal side range
  assign cfg_ext  = CALC_W'(cfg_wdata);
  assign cfg_side = (cfg_ext < CALC_W'(SIDE_MIN)) ? SIDE_W'(SIDE_MIN) :
                    (cfg_ext > CALC_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(cfg_ext);

  always_comb begin
    result         = '0;
    cursor_x_nxt   = cursor_x_r;
    shelf_top_nxt  = shelf_top_r;
    shelf_tall_nxt = shelf_tall_r;
    atlas_side_nxt = atlas_side_r;
    if (cfg_we) begin
      cursor_x_nxt   = '0;
      shelf_top_nxt  = '0;
      shelf_tall_nxt = '0;
      atlas_side_nxt = cfg_side;
    end else if (in_accept) begin
      if (in_data.operation == OP_CLEAR) begin
        cursor_x_nxt   = '0;
        shelf_top_nxt  = '0;
        shelf_tall_nxt = '0;
      end else if (!empty_rect) begin
        if (vfail && at_max) begin
          result.no_room = 1'b1;
        end else begin
          result.pos_u         = 13'(nx_fin);
          result.pos_v         = ny_fin[12:0];
          result.placed_width  = aw;
          result.placed_height = in_data.bitmap_height;
          result.grew          = vfail;
          cursor_x_nxt   = CURSOR_W'(CALC_W'(nx_fin) + CALC_W'(aw) + CALC_W'(1));
          shelf_top_nxt  = ny_fin[CURSOR_W-1:0];
          shelf_tall_nxt = (nt_fin > in_data.bitmap_height) ? nt_fin : in_data.bitmap_height;
          if (vfail) begin
            atlas_side_nxt = side_grown;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r   <= '0;
      shelf_top_r  <= '0;
      shelf_tall_r <= '0;
      atlas_side_r <= SIDE_W'(RESET_SIDE);
    end else begin
      cursor_x_r   <= cursor_x_nxt;
      shelf_top_r  <= shelf_top_nxt;
      shelf_tall_r <= shelf_tall_nxt;
      atlas_side_r <= atlas_side_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_accept) begin
      if (out_valid_r && !out_take) begin
        skid_data_r <= result;
      end else begin
        out_data_r <= result;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a beat while the output register is empty");

  a_side_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CALC_W'(atlas_side_r) >= CALC_W'(SIDE_MIN)) && (CALC_W'(atlas_side_r) <= CALC_W'(MAX_SIDE)))
    else $error("atlas side out of range");

  a_side_no_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> atlas_side_r >= $past(atlas_side_r))
    else $error("atlas side shrank without a register write");

  a_grew_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.grew) |->
      (out_data_r.pos_u == '0 && out_data_r.pos_v == '0 && !out_data_r.no_room))
    else $error("grown atlas placement not at origin");

  a_no_room_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.no_room) |->
      (out_data_r.placed_width == '0 && out_data_r.placed_height == '0))
    else $error("no_room beat carries a placement");

endmodule
